### design/ecpu_pkg.sv
// ----------------------------------------------------------------------------
// ecpu_pkg
// Shared types and constants for the 8-bit cpu execute unit.
// ----------------------------------------------------------------------------
package ecpu_pkg;

    localparam int RegCount   = 8;
    localparam int RegIdxW    = $clog2(RegCount);
    localparam int DataW      = 8;
    localparam int InstrW     = 20;
    localparam int NibbleW    = 4;
    localparam int InTdataW   = 32;
    localparam int OutTdataW  = 40;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_ADDI   = 3'd1,
        OP_MUL    = 3'd2,
        OP_INV    = 3'd3,
        OP_BRANCH = 3'd4,
        OP_LW     = 3'd5,
        OP_SW     = 3'd6,
        OP_HALT   = 3'd7
    } t_opcode;

    localparam logic [RegIdxW-1:0] BR_EQ = 3'd0;
    localparam logic [RegIdxW-1:0] BR_NE = 3'd1;
    localparam logic [RegIdxW-1:0] BR_LT = 3'd2;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic ACT_EXEC = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

endpackage

### design/eight_bit_cpu_execute_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit
// Executes one instruction or load return per beat against an eight-entry
// register file, program counter and halt flag.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                   tuser
// s_axis   in   instruction_word, load_data             action
// m_axis   out  next_pc .. halted (one result per beat)  -
//
// one beat in, one beat out; an input and register read stage, then an
// execute stage into the result register
// a new beat is taken every cycle while the result side keeps up
// i_rst_n clears the registers, pc, pending load index, halt flag and valids
// a stalled result holds both stages; tready drops once the input stage is
// full and cannot move on
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit
    import ecpu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [19:0] instruction_word, [27:20] load_data, [31:28] zero
    input  logic [InTdataW-1:0]  i_s_axis_tdata,
    // [0] action
    input  logic [0:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] next_pc, [9:8] mem_request, [17:10] mem_address,
    // [25:18] mem_write_data, [26] reg_written, [29:27] reg_index,
    // [37:30] reg_value, [38] halted, [39] zero
    output logic [OutTdataW-1:0] o_m_axis_tdata
);

    // register file
    logic [DataW-1:0]    r_rf [RegCount];
    logic [RegCount-1:0] r_rf_vld;

    // input stage
    logic               r_in_valid;
    logic               r_act;
    t_opcode            r_op;
    logic [RegIdxW-1:0] r_d;
    logic [DataW-1:0]   r_imm;
    logic [DataW-1:0]   r_ld;
    logic [DataW-1:0]   r_rs;
    logic [DataW-1:0]   r_rt;

    // architectural state
    logic [DataW-1:0]   r_pc;
    logic [RegIdxW-1:0] r_pend;
    logic               r_halt;

    // result register
    logic                 r_out_valid;
    logic [OutTdataW-1:0] r_out;

    logic               w_adv;
    logic               w_acc;
    logic [InstrW-1:0]  w_instr;
    logic [RegIdxW-1:0] w_s_in;
    logic [RegIdxW-1:0] w_t_in;

    logic               n_wr;
    logic [RegIdxW-1:0] n_widx;
    logic [DataW-1:0]   n_wval;
    logic [DataW-1:0]   n_pc;
    logic [1:0]         n_req;
    logic [DataW-1:0]   n_addr;
    logic [DataW-1:0]   n_wdata;
    logic               n_halt;
    logic [RegIdxW-1:0] n_pend;
    logic               w_taken;
    logic [2*NibbleW-1:0] w_prod;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_instr         = i_s_axis_tdata[InstrW-1:0];
    assign w_s_in          = w_instr[13:11];
    assign w_t_in          = w_instr[10:8];

    assign w_prod = (2*NibbleW)'(r_rs[DataW-1:NibbleW]) * (2*NibbleW)'(r_rs[NibbleW-1:0]);

    always_comb begin
        case (r_d)
            BR_EQ:   w_taken = (r_rs == r_rt);
            BR_NE:   w_taken = (r_rs != r_rt);
            BR_LT:   w_taken = ($signed(r_rs) < $signed(r_rt));
            default: w_taken = 1'b0;
        endcase
    end

    always_comb begin
        n_wr    = 1'b0;
        n_widx  = '0;
        n_wval  = '0;
        n_pc    = r_pc;
        n_req   = MEM_NONE;
        n_addr  = '0;
        n_wdata = '0;
        n_halt  = r_halt;
        n_pend  = r_pend;
        if (!r_halt) begin
            if (r_act == ACT_LOAD) begin
                n_wr   = 1'b1;
                n_widx = r_pend;
                n_wval = r_ld;
            end else begin
                n_pc = r_pc + DataW'(1);
                case (r_op)
                    OP_ADD: begin
                        n_wr = 1'b1; n_widx = r_d; n_wval = r_rs + r_rt;
                    end
                    OP_ADDI: begin
                        n_wr = 1'b1; n_widx = r_d; n_wval = r_rs + r_imm;
                    end
                    OP_MUL: begin
                        n_wr = 1'b1; n_widx = r_d; n_wval = w_prod;
                    end
                    OP_INV: begin
                        n_wr = 1'b1; n_widx = r_d; n_wval = ~r_rs;
                    end
                    OP_BRANCH: begin
                        if (w_taken) begin
                            n_pc = r_imm;
                        end
                    end
                    OP_LW: begin
                        n_req = MEM_READ; n_addr = r_rt; n_pend = r_d;
                    end
                    OP_SW: begin
                        n_req = MEM_WRITE; n_addr = r_rt; n_wdata = r_rs;
                    end
                    default: begin
                        n_halt = 1'b1;
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_pend      <= '0;
            r_halt      <= 1'b0;
            r_rf_vld    <= '0;
        end else begin
            if (w_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
                r_pend      <= n_pend;
                r_halt      <= n_halt;
                if (n_wr) begin
                    r_rf_vld[n_widx] <= 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // register file write
    always_ff @(posedge i_clk) begin
        if (w_adv && n_wr) begin
            r_rf[n_widx] <= n_wval;
        end
    end

    // input capture and register read, forwarding the write made at this edge
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_act <= i_s_axis_tuser[0];
            r_op  <= t_opcode'(w_instr[19:17]);
            r_d   <= w_instr[16:14];
            r_imm <= w_instr[DataW-1:0];
            r_ld  <= i_s_axis_tdata[InstrW+DataW-1:InstrW];
            if (w_adv && n_wr && n_widx == w_s_in) begin
                r_rs <= n_wval;
            end else begin
                r_rs <= r_rf_vld[w_s_in] ? r_rf[w_s_in] : '0;
            end
            if (w_adv && n_wr && n_widx == w_t_in) begin
                r_rt <= n_wval;
            end else begin
                r_rt <= r_rf_vld[w_t_in] ? r_rf[w_t_in] : '0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= {1'b0, n_halt, n_wval, n_widx, n_wr, n_wdata, n_addr, n_req, n_pc};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // once halted the block stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // a full input stage with an empty result register always moves on
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("input stage did not advance into an empty result register");

    // no register write reports a stray index or value
    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out[26]) |-> (r_out[29:27] == '0 && r_out[37:30] == '0))
        else $error("register index or value set without a write");

    // a halted result carries no memory request and no register write
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[38]) |-> (r_out[9:8] == MEM_NONE && !r_out[26]))
        else $error("halted result carries side effects");

    // the request code never takes the unused value
    a_req_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out[9:8] == MEM_NONE || r_out[9:8] == MEM_READ ||
                         r_out[9:8] == MEM_WRITE))
        else $error("undefined memory request code");

endmodule

### test/ecpu_exec_checker.sv
// ----------------------------------------------------------------------------
// ecpu_exec_checker
// Watches both stream channels of the execute unit. Every accepted input
// beat is run through a local copy of the register file, pc, pending load
// index and halt flag, and the result it should produce is queued. Every
// accepted output beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module ecpu_exec_checker
    import ecpu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    input  logic                 i_s_axis_tready,
    // [19:0] instruction_word, [27:20] load_data, [31:28] zero
    input  logic [InTdataW-1:0]  i_s_axis_tdata,
    // [0] action
    input  logic [0:0]           i_s_axis_tuser,
    input  logic                 i_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] next_pc, [9:8] mem_request, [17:10] mem_address,
    // [25:18] mem_write_data, [26] reg_written, [29:27] reg_index,
    // [37:30] reg_value, [38] halted, [39] zero
    input  logic [OutTdataW-1:0] i_m_axis_tdata,
    output int                   o_outstanding,
    output int                   o_errors
);

    // packed msb first so that a cast of tdata[38:0] lines up
    typedef struct packed {
        logic               halted;
        logic [DataW-1:0]   reg_value;
        logic [RegIdxW-1:0] reg_index;
        logic               reg_written;
        logic [DataW-1:0]   mem_write_data;
        logic [DataW-1:0]   mem_address;
        logic [1:0]         mem_request;
        logic [DataW-1:0]   next_pc;
    } t_exec_result;

    logic [DataW-1:0]   gpr [RegCount];
    logic [DataW-1:0]   pc_q;
    logic [RegIdxW-1:0] load_dst;
    logic               frozen;

    t_exec_result expected_results[$];
    int           err_cnt    = 0;
    int           result_num = 0;

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= 50) begin
            $display("ERROR: result %0d: %s", result_num, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic execute_beat(input logic act, input logic [InstrW-1:0] word,
                                input logic [DataW-1:0] ld,
                                output t_exec_result r);
        t_opcode            op;
        logic [RegIdxW-1:0] d;
        logic [RegIdxW-1:0] s;
        logic [RegIdxW-1:0] t;
        logic [DataW-1:0]   imm;
        logic [DataW-1:0]   rs;
        logic [DataW-1:0]   rt;
        logic               taken;
        op  = t_opcode'(word[19:17]);
        d   = word[16:14];
        s   = word[13:11];
        t   = word[10:8];
        imm = word[7:0];
        r   = '0;
        r.next_pc = pc_q;
        if (!frozen) begin
            rs = gpr[s];
            rt = gpr[t];
            if (act == ACT_LOAD) begin
                // writes the pending index even with no load outstanding
                r.reg_written = 1'b1;
                r.reg_index   = load_dst;
                r.reg_value   = ld;
            end else begin
                r.next_pc = pc_q + 8'd1;
                case (op)
                    OP_ADD: begin
                        r.reg_written = 1'b1;
                        r.reg_index   = d;
                        r.reg_value   = rs + rt;
                    end
                    OP_ADDI: begin
                        r.reg_written = 1'b1;
                        r.reg_index   = d;
                        r.reg_value   = rs + imm;
                    end
                    OP_MUL: begin
                        r.reg_written = 1'b1;
                        r.reg_index   = d;
                        r.reg_value   = 8'(rs[7:4]) * 8'(rs[3:0]);
                    end
                    OP_INV: begin
                        r.reg_written = 1'b1;
                        r.reg_index   = d;
                        r.reg_value   = ~rs;
                    end
                    OP_BRANCH: begin
                        case (d)
                            BR_EQ:   taken = (rs == rt);
                            BR_NE:   taken = (rs != rt);
                            BR_LT:   taken = ($signed(rs) < $signed(rt));
                            default: taken = 1'b0;
                        endcase
                        if (taken) begin
                            r.next_pc = imm;
                        end
                    end
                    OP_LW: begin
                        r.mem_request = MEM_READ;
                        r.mem_address = rt;
                        load_dst      = d;
                    end
                    OP_SW: begin
                        r.mem_request    = MEM_WRITE;
                        r.mem_address    = rt;
                        r.mem_write_data = rs;
                    end
                    default: begin
                        frozen = 1'b1;
                    end
                endcase
            end
            if (r.reg_written) begin
                gpr[r.reg_index] = r.reg_value;
            end
            pc_q = r.next_pc;
        end
        r.halted = frozen;
    endtask

    always @(posedge i_clk) begin
        t_exec_result got;
        t_exec_result want;
        if (!i_rst_n) begin
            foreach (gpr[i]) gpr[i] = '0;
            pc_q     = '0;
            load_dst = '0;
            frozen   = 1'b0;
            expected_results.delete();
        end else begin
            // retire first: a result never belongs to a beat taken at the same edge
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_exec_result'(i_m_axis_tdata[38:0]);
                if (expected_results.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    check_field("next_pc", got.next_pc, want.next_pc);
                    check_field("mem_request", 8'(got.mem_request), 8'(want.mem_request));
                    check_field("mem_address", got.mem_address, want.mem_address);
                    check_field("mem_write_data", got.mem_write_data,
                                want.mem_write_data);
                    check_field("reg_written", 8'(got.reg_written), 8'(want.reg_written));
                    check_field("reg_index", 8'(got.reg_index), 8'(want.reg_index));
                    check_field("reg_value", got.reg_value, want.reg_value);
                    check_field("halted", 8'(got.halted), 8'(want.halted));
                end
                result_num++;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                execute_beat(i_s_axis_tuser[0], i_s_axis_tdata[19:0],
                             i_s_axis_tdata[27:20], want);
                expected_results.push_back(want);
            end
        end
        o_outstanding <= expected_results.size();
        o_errors      <= err_cnt;
    end

endmodule

### test/eight_bit_cpu_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit_tb
// Drives instruction and load return beats into the execute unit: a directed
// run over every opcode but halt, each branch kind and wrap case, then random
// programs with loads mostly followed by their return, under several idle and
// stall mixes, and finally a halt followed by beats that must change nothing.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit_tb;
    import ecpu_pkg::*;

    localparam int                 WatchdogLimit = 1000;
    localparam logic [RegIdxW-1:0] BR_SPARE_LO   = 3'd3;
    localparam logic [RegIdxW-1:0] BR_SPARE_HI   = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_valid  = 1'b0;
    logic [InTdataW-1:0]  s_data   = '0;
    logic [0:0]           s_user   = '0;
    logic                 m_ready  = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [OutTdataW-1:0] o_m_axis_tdata;

    int   outstanding;
    int   errors;
    int   src_idle   = 0;
    int   sink_stall = 0;
    int   idle_cycles;
    logic last_was_load;

    eight_bit_cpu_execute_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    ecpu_exec_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .o_outstanding   (outstanding),
        .o_errors        (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_ready <= i_rst_n && ($urandom_range(99) >= sink_stall);
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_valid && o_s_axis_tready) ||
                (o_m_axis_tvalid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [InstrW-1:0] instr(t_opcode op, logic [2:0] d,
                                                logic [2:0] s, logic [2:0] t,
                                                logic [7:0] imm);
        return {op, d, s, t, imm};
    endfunction

    task automatic send_beat(input logic act, input logic [InstrW-1:0] word,
                             input logic [DataW-1:0] ld);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {4'b0, ld, word};
        s_user  <= act;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic send_exec(input logic [InstrW-1:0] word);
        send_beat(ACT_EXEC, word, 8'($urandom));
    endtask

    task automatic send_load(input logic [DataW-1:0] ld);
        send_beat(ACT_LOAD, 20'($urandom), ld);
    endtask

    // hold the sender off until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic run_random(input int count, input int src, input int snk);
        logic              act;
        logic [InstrW-1:0] word;
        src_idle   = src;
        sink_stall = snk;
        for (int i = 0; i < count; i++) begin
            word        = 20'($urandom);
            // halt stays out of the random part, it would freeze the block
            word[19:17] = 3'($urandom_range(OP_SW, OP_ADD));
            // mostly a return right after a load, now and then a stray one
            act = last_was_load ? ($urandom_range(99) < 75) : ($urandom_range(99) < 8);
            send_beat(act, word, 8'($urandom));
            last_was_load = (act == ACT_EXEC) && (word[19:17] == OP_LW);
        end
        wait_drained();
    endtask

    initial begin
        last_was_load = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the arithmetic
        send_exec(instr(OP_ADDI, 3'd1, 3'd0, 3'd0, 8'hFF));
        send_exec(instr(OP_ADDI, 3'd2, 3'd0, 3'd7, 8'h7F));
        send_exec(instr(OP_ADDI, 3'd3, 3'd0, 3'd0, 8'h80));
        send_exec(instr(OP_ADD, 3'd4, 3'd1, 3'd1, 8'h00));
        send_exec(instr(OP_MUL, 3'd5, 3'd1, 3'd0, 8'h00));
        send_exec(instr(OP_MUL, 3'd6, 3'd2, 3'd0, 8'hFF));
        send_exec(instr(OP_INV, 3'd7, 3'd0, 3'd0, 8'h00));
        send_exec(instr(OP_INV, 3'd0, 3'd1, 3'd5, 8'h00));
        // taken branch to the top of memory, then pc wraps to zero
        send_exec(instr(OP_BRANCH, BR_EQ, 3'd1, 3'd1, 8'hFF));
        send_exec(instr(OP_ADDI, 3'd0, 3'd0, 3'd0, 8'h00));
        send_exec(instr(OP_BRANCH, BR_NE, 3'd1, 3'd1, 8'h12));
        send_exec(instr(OP_BRANCH, BR_NE, 3'd1, 3'd2, 8'h00));
        // signed compare: 0x80 is below 0x7f
        send_exec(instr(OP_BRANCH, BR_LT, 3'd3, 3'd2, 8'h55));
        send_exec(instr(OP_BRANCH, BR_LT, 3'd2, 3'd3, 8'hAA));
        send_exec(instr(OP_BRANCH, BR_LT, 3'd1, 3'd1, 8'h44));
        // spare branch kinds fall through
        send_exec(instr(OP_BRANCH, BR_SPARE_LO, 3'd1, 3'd1, 8'h33));
        send_exec(instr(OP_BRANCH, BR_SPARE_HI, 3'd1, 3'd1, 8'h77));
        send_exec(instr(OP_LW, 3'd6, 3'd0, 3'd1, 8'h00));
        send_load(8'hAB);
        // return with no load outstanding
        send_load(8'h00);
        send_exec(instr(OP_SW, 3'd0, 3'd1, 3'd3, 8'h00));
        send_exec(instr(OP_SW, 3'd7, 3'd0, 3'd0, 8'hFF));
        wait_drained();

        run_random(400, 0, 0);
        run_random(350, 46, 0);
        run_random(350, 0, 46);
        run_random(400, 35, 35);
        run_random(200, 0, 0);

        // halt, then everything must be ignored
        src_idle   = 20;
        sink_stall = 20;
        send_exec(instr(OP_HALT, 3'd5, 3'd2, 3'd6, 8'h9C));
        send_exec(instr(OP_ADDI, 3'd1, 3'd1, 3'd0, 8'h01));
        send_exec(instr(OP_LW, 3'd2, 3'd0, 3'd4, 8'h00));
        send_load(8'h5A);
        send_exec(instr(OP_SW, 3'd0, 3'd3, 3'd2, 8'h00));
        send_exec(instr(OP_BRANCH, BR_EQ, 3'd0, 3'd0, 8'h10));
        send_exec(instr(OP_HALT, 3'd0, 3'd0, 3'd0, 8'h00));

        sink_stall = 0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
